@@ hdl/markup_tag_nesting_checker_top_defines.svh @@
// ----------------------------------------------------------------------------
// Markup tag nesting checker: assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef MARKUP_TAG_NESTING_CHECKER_TOP_DEFINES_SVH
`define MARKUP_TAG_NESTING_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication
`define TNC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define TNC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/tnc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tag nesting checker package
// Sizes, character codes, status codes and shared types.
// ----------------------------------------------------------------------------
package tnc_pkg;

   // Sizing
   localparam int STACK_DEPTH = 64;
   localparam int NAME_LEN    = 32;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int TOP_W       = $clog2(STACK_DEPTH);
   localparam int CI_W        = $clog2(NAME_LEN + 1);
   localparam int MEM_DEPTH   = STACK_DEPTH * NAME_LEN;
   localparam int ADDR_W      = $clog2(MEM_DEPTH);
   localparam int LINE_W      = 24;
   localparam int DEPTH_W     = 7;

   localparam logic [LINE_W-1:0] LINE_MAX = 24'hFFFFFF;

   // Character codes
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_MISMATCH = 3'd1,
      STS_EMPTY    = 3'd2,
      STS_UNCLOSED = 3'd3,
      STS_OVERFLOW = 3'd4,
      STS_TOO_LONG = 3'd5
   } status_type;

   // Length stack control
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   // One result
   typedef struct packed {
      status_type           status;
      logic [LINE_W-1:0]    line;
      logic [DEPTH_W-1:0]   depth;
   } rsp_type;

endpackage : tnc_pkg
`default_nettype wire

@@ hdl/markup_tag_nesting_checker_top.sv @@
// Markup tag nesting checker. Takes one document byte per request and runs at
// one request per clock cycle while the output queue has room; a result, when
// a byte causes one, is ready in the cycle after that request. The rate is set
// by the tag name memory: each tag byte is either one write into it or one
// compare against a stored byte that was read out in the previous cycle for
// the next expected position. Tag name lengths sit in a row of stack cells
// whose first cell is always the top of stack. Results pass through a
// two-entry output queue, so requests keep flowing while a result waits; the
// input stalls only when both entries are full. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Markup tag nesting checker, top level
// Tag parsing, name memory, length stack and result queue.
// ----------------------------------------------------------------------------
module markup_tag_nesting_checker_top
   import tnc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic [0:0]  req_tuser,   // [0] end_of_document
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [23:0] line_number, [30:24] open_depth
   output logic [2:0]       rsp_tuser    // [2:0] status
);

   // Parser state
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic              inside_ff, inside_in;
   logic              closing_ff, closing_in;
   logic [CI_W-1:0]   ci_ff, ci_in;
   logic              fail_ff, fail_in;
   logic [LINE_W-1:0] line_ff, line_in;
   status_type        err_ff, err_in;

   logic [7:0]        mem [MEM_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [TOP_W-1:0]  rd_top;
   logic              mem_we;

   stack_ctl_type     stk_ctl;
   logic [CI_W-1:0]   top_len;

   logic              acc, eod;
   logic [7:0]        ch;
   logic              emit;
   rsp_type           emit_rsp;
   logic [DEPTH_W-1:0] depth_sat;

   rsp_type           q_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        cnt_ff, cnt_in;
   logic              q_push, q_pop;

   assign acc = req_tvalid && req_tready;
   assign eod = req_tuser[0];
   assign ch  = req_tdata;

   assign depth_sat = (32'(sp_ff) > 32'd127) ? 7'd127 : DEPTH_W'(sp_ff);

   // Per-request parsing
   always_comb begin
      sp_in      = sp_ff;
      inside_in  = inside_ff;
      closing_in = closing_ff;
      ci_in      = ci_ff;
      fail_in    = fail_ff;
      line_in    = line_ff;
      err_in     = err_ff;
      mem_we     = 1'b0;
      stk_ctl    = '0;
      emit       = 1'b0;
      emit_rsp.status = STS_OK;
      emit_rsp.depth  = depth_sat;
      emit_rsp.line   = line_ff;

      if (acc) begin
         if (eod) begin
            // final report, then back to reset state
            emit = 1'b1;
            if (err_ff != STS_OK) begin
               emit_rsp.status = err_ff;
            end else if (sp_ff == '0) begin
               emit_rsp.status = STS_OK;
            end else begin
               emit_rsp.status = STS_UNCLOSED;
            end
            sp_in      = '0;
            inside_in  = 1'b0;
            closing_in = 1'b0;
            ci_in      = '0;
            fail_in    = 1'b0;
            line_in    = LINE_W'(1);
            err_in     = STS_OK;
         end else begin
            if (ch == CH_NL && line_ff < LINE_MAX) begin
               line_in = line_ff + LINE_W'(1);
            end
            emit_rsp.line = line_in;

            if (err_ff != STS_OK) begin
               // sticky error: only line counting goes on
            end else if (!inside_ff) begin
               if (ch == CH_LT) begin
                  inside_in  = 1'b1;
                  closing_in = 1'b0;
                  ci_in      = '0;
                  fail_in    = 1'b0;
               end
            end else if (ch == CH_GT) begin
               inside_in = 1'b0;
               if (closing_ff) begin
                  if (sp_ff == '0) begin
                     emit            = 1'b1;
                     emit_rsp.status = STS_EMPTY;
                     err_in          = STS_EMPTY;
                  end else if (fail_ff || ci_ff != top_len) begin
                     emit            = 1'b1;
                     emit_rsp.status = STS_MISMATCH;
                     err_in          = STS_MISMATCH;
                  end else begin
                     stk_ctl.pop = 1'b1;
                     sp_in       = sp_ff - SP_W'(1);
                  end
               end else begin
                  if (32'(sp_ff) >= STACK_DEPTH) begin
                     emit            = 1'b1;
                     emit_rsp.status = STS_OVERFLOW;
                     err_in          = STS_OVERFLOW;
                  end else begin
                     stk_ctl.push = 1'b1;
                     sp_in        = sp_ff + SP_W'(1);
                  end
               end
            end else if (ci_ff == '0 && !closing_ff && ch == CH_SLASH) begin
               closing_in = 1'b1;
            end else if (32'(ci_ff) >= NAME_LEN) begin
               emit            = 1'b1;
               emit_rsp.status = STS_TOO_LONG;
               err_in          = STS_TOO_LONG;
               inside_in       = 1'b0;
            end else begin
               if (closing_ff) begin
                  // compare against the prefetched byte of the top name
                  if (sp_ff != '0 && 32'(sp_ff) <= STACK_DEPTH) begin
                     if (ci_ff >= top_len || rd_data_ff != ch) begin
                        fail_in = 1'b1;
                     end
                  end
               end else if (32'(sp_ff) < STACK_DEPTH) begin
                  mem_we = 1'b1;
               end
               ci_in = ci_ff + CI_W'(1);
            end
         end
      end
   end

   // Parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff      <= '0;
         inside_ff  <= 1'b0;
         closing_ff <= 1'b0;
         ci_ff      <= '0;
         fail_ff    <= 1'b0;
         line_ff    <= LINE_W'(1);
         err_ff     <= STS_OK;
      end else begin
         sp_ff      <= sp_in;
         inside_ff  <= inside_in;
         closing_ff <= closing_in;
         ci_ff      <= ci_in;
         fail_ff    <= fail_in;
         line_ff    <= line_in;
         err_ff     <= err_in;
      end
   end

   // Name memory: write the byte being pushed, prefetch the next compare byte
   assign rd_top  = TOP_W'(sp_in - SP_W'(1));
   assign wr_addr = ADDR_W'(sp_ff) * ADDR_W'(NAME_LEN) + ADDR_W'(ci_ff);
   assign rd_addr = ADDR_W'(rd_top) * ADDR_W'(NAME_LEN) + ADDR_W'(ci_in);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= ch;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Tag length stack
   tnc_len_stack u_len_stack (
      .clock    (clock),
      .ctl      (stk_ctl),
      .push_len (ci_ff),
      .top_len  (top_len)
   );

   // Two-entry result queue
   assign q_push     = emit;
   assign q_pop      = rsp_tvalid && rsp_tready;
   assign req_tready = (cnt_ff != 2'd2);
   assign cnt_in     = cnt_ff + 2'(q_push) - 2'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (q_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[wr_ptr_ff] <= emit_rsp;
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tuser  = q_ff[rd_ptr_ff].status;
   assign rsp_tdata  = {1'b0, q_ff[rd_ptr_ff].depth, q_ff[rd_ptr_ff].line};

endmodule : markup_tag_nesting_checker_top
`default_nettype wire

@@ hdl/tnc_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Length stack cell
// Holds one tag name length; shifts toward deeper cells on push and back on pop.
// ----------------------------------------------------------------------------
module tnc_cell
   import tnc_pkg::*;
(
   input  wire logic            clock,
   input  wire stack_ctl_type   ctl,
   input  wire logic [CI_W-1:0] prev_len,   // from the cell nearer the top
   input  wire logic [CI_W-1:0] next_len,   // from the cell deeper down
   output logic [CI_W-1:0]      len_out
);

   logic [CI_W-1:0] len_ff;

   // shift one place per push or pop
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         len_ff <= prev_len;
      end else if (ctl.pop) begin
         len_ff <= next_len;
      end
   end

   assign len_out = len_ff;

endmodule : tnc_cell
`default_nettype wire

@@ hdl/tnc_len_stack.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Length stack
// Row of cells; cell 0 is always the top of stack.
// ----------------------------------------------------------------------------
module tnc_len_stack
   import tnc_pkg::*;
(
   input  wire logic            clock,
   input  wire stack_ctl_type   ctl,
   input  wire logic [CI_W-1:0] push_len,
   output logic [CI_W-1:0]      top_len
);

   logic [CI_W-1:0] len_w [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [CI_W-1:0] prev_w;
      logic [CI_W-1:0] next_w;

      if (i == 0) begin : g_head
         assign prev_w = push_len;
      end else begin : g_body
         assign prev_w = len_w[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_tail
         assign next_w = '0;
      end else begin : g_link
         assign next_w = len_w[i+1];
      end

      tnc_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .prev_len (prev_w),
         .next_len (next_w),
         .len_out  (len_w[i])
      );
   end

   assign top_len = len_w[0];

endmodule : tnc_len_stack
`default_nettype wire

@@ hdl/tnc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tag nesting checker port assertions
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
`include "markup_tag_nesting_checker_top_defines.svh"

module tnc_checker
   import tnc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,   // [7:0] char_code
   input wire logic [0:0]  req_tuser,   // [0] end_of_document
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,   // [23:0] line_number, [30:24] open_depth
   input wire logic [2:0]  rsp_tuser    // [2:0] status
);

   // status code stays within the defined set
   `TNC_ASSERT_IMP(a_status_range, clock, reset, rsp_tvalid, rsp_tuser <= STS_TOO_LONG, "status out of range")

   // line numbers start at one and never wrap to zero
   `TNC_ASSERT_IMP(a_line_nonzero, clock, reset, rsp_tvalid, rsp_tdata[23:0] != 24'd0, "line zero")

   // a clean report means nothing is left open
   `TNC_ASSERT_IMP(a_ok_empty, clock, reset, rsp_tvalid && rsp_tuser == STS_OK, rsp_tdata[30:24] == 7'd0, "ok with open tags")

   // stalled result holds
   `TNC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed under stall")

endmodule : tnc_checker

bind markup_tag_nesting_checker_top tnc_checker u_tnc_checker (.*);
`default_nettype wire
